// ===== rtl/sfpcd_pkg.sv =====
// shared types and constants of the status frame parser with change detection
`default_nettype none

package sfpcd_pkg;

  // result status reported with every closed frame
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_CMD     = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_BAD_HDR = 3'd3,
    ST_BAD_SUM = 3'd4
  } status_t;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_WINDOW = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BURST_LIMIT = 1'b1;

  // configuration reset values
  localparam logic [15:0] TEMP_WINDOW_RST = 16'd2000;
  localparam logic [3:0]  BURST_LIMIT_RST = 4'd10;

  // frame constants
  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] CMD_TYPE = 8'h02;

  // byte positions inside a frame
  localparam int unsigned B_HDR0   = 0;
  localparam int unsigned B_HDR1   = 1;
  localparam int unsigned B_TYPE   = 3;
  localparam int unsigned B_FIELD0 = 4;
  localparam int unsigned B_TEMP   = 10;
  localparam int unsigned B_HOUR   = 13;
  localparam int unsigned B_MIN    = 14;
  localparam int unsigned B_FAULT  = 15;

  // stored field slots
  localparam int unsigned NUM_FIELDS  = 8;
  localparam int unsigned NUM_CMP     = 6;
  localparam int unsigned SLOT_TEMP   = 6;
  localparam int unsigned SLOT_FAULT  = 7;

  // stream widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 96;

endpackage

`default_nettype wire

// ===== rtl/status_frame_parser_change_detect_top.sv =====
// top level: byte-stream status frame parser, checker and change detector
// a frame's result is registered when its last byte leaves the input register
// throughput: one byte per cycle; only a last byte waits, and only while the result
//   register holds a result that is not taken in the same cycle
// reset (rst_n low, synchronous): counters, stored fields and timers clear, config regs
//   return to window 2000 ms and burst limit 10; no result is pending
`default_nettype none

module status_frame_parser_change_detect_top #(
  parameter int unsigned FRAME_LEN = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [sfpcd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [sfpcd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input byte stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // in_tdata: data_byte[7:0], now_ms[39:8]
  input  wire logic [sfpcd_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                 in_tlast,
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // out_tdata: command_code[7:0], changed[8], on_off[16:9], heating[24:17],
  //   appoint[32:25], work_mode[40:33], power_level[48:41], temp_target[56:49],
  //   temp_now[64:57], appoint_time[80:65], fault_code[88:81], zero fill above
  output logic [sfpcd_pkg::OUT_DATA_W-1:0]          out_tdata,
  // out_tuser: frame_status[2:0]
  output sfpcd_pkg::status_t                        out_tuser
);

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam int unsigned CNT_W = $clog2(FRAME_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_SUM  = CNT_W'(FRAME_LEN - 2);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(FRAME_LEN + 1);
  localparam logic [IDX_W-1:0] IDX_TRL_HI = IDX_W'(FRAME_LEN - 2);

  // configuration registers
  logic [15:0] temp_window_r;
  logic [3:0]  burst_limit_r;

  // input register
  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        s1_end_r;
  logic [31:0] s1_now_r;
  logic        s1_go;

  // frame state
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [15:0]      sum_r;
  logic [15:0]      sum_nxt;
  logic [7:0]       frame_r [FRAME_LEN];

  // stored fields and filter state
  logic [7:0]  stored_r [sfpcd_pkg::NUM_FIELDS];
  logic [7:0]  new_f    [sfpcd_pkg::NUM_FIELDS];
  logic [7:0]  rep_f    [sfpcd_pkg::NUM_FIELDS];
  logic [7:0]  hour_r;
  logic [7:0]  minute_r;
  logic [31:0] last_ms_r;
  logic [3:0]  tcount_r;
  logic [3:0]  tcount_nxt;

  // result register
  logic                              out_vld_r;
  logic [sfpcd_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [sfpcd_pkg::OUT_DATA_W-1:0]  out_data_nxt;
  sfpcd_pkg::status_t                out_status_r;

  // frame check signals
  logic               len_ok;
  logic               hdr_ok;
  logic               sum_ok;
  logic [15:0]        trailer;
  sfpcd_pkg::status_t status;
  logic               is_data;
  logic [7:0]         cmd_code;
  logic               chg_main;
  logic               chg_time;
  logic               temp_reached;
  logic               temp_fast;
  logic               temp_report;
  logic               changed;
  logic [31:0]        elapsed;
  logic [15:0]        atime;

  // handshake: only a last byte waits for the result register
  assign s1_go     = s1_vld_r && (!s1_end_r || !out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata[7:0];
      s1_end_r  <= in_tlast;
      s1_now_r  <= in_tdata[39:8];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_window_r <= sfpcd_pkg::TEMP_WINDOW_RST;
      burst_limit_r <= sfpcd_pkg::BURST_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        sfpcd_pkg::REG_TEMP_WINDOW: temp_window_r <= cfg_wdata;
        sfpcd_pkg::REG_BURST_LIMIT: burst_limit_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // byte count and running checksum
  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (cnt_r < CNT_SUM) begin
      sum_nxt = sum_r + {8'd0, s1_byte_r};
    end
    if (cnt_r < CNT_SAT) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (s1_end_r) begin
      cnt_nxt = '0;
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else if (s1_go) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  // frame byte store
  always_ff @(posedge clk) begin
    if (s1_go && (cnt_r < CNT_FULL)) begin
      frame_r[cnt_r[IDX_W-1:0]] <= s1_byte_r;
    end
  end

  // frame checks; the last trailer byte is the one in the input register
  assign len_ok  = (cnt_r == CNT_LAST);
  assign hdr_ok  = (frame_r[IDX_W'(sfpcd_pkg::B_HDR0)] == sfpcd_pkg::HDR_BYTE) &&
                   (frame_r[IDX_W'(sfpcd_pkg::B_HDR1)] == sfpcd_pkg::HDR_BYTE);
  assign trailer = {frame_r[IDX_TRL_HI], s1_byte_r};
  assign sum_ok  = (trailer == sum_r);

  always_comb begin
    cmd_code = 8'd0;
    if (!len_ok) begin
      status = sfpcd_pkg::ST_BAD_LEN;
    end else if (!hdr_ok) begin
      status = sfpcd_pkg::ST_BAD_HDR;
    end else if (!sum_ok) begin
      status = sfpcd_pkg::ST_BAD_SUM;
    end else if (frame_r[IDX_W'(sfpcd_pkg::B_TYPE)] == sfpcd_pkg::CMD_TYPE) begin
      status   = sfpcd_pkg::ST_CMD;
      cmd_code = frame_r[IDX_W'(sfpcd_pkg::B_FIELD0)];
    end else begin
      status = sfpcd_pkg::ST_DATA;
    end
  end

  assign is_data = (status == sfpcd_pkg::ST_DATA);

  // new field values from the frame
  always_comb begin
    for (int i = 0; i < sfpcd_pkg::SLOT_FAULT; i++) begin
      new_f[i] = frame_r[IDX_W'(sfpcd_pkg::B_FIELD0 + i)];
    end
    new_f[sfpcd_pkg::SLOT_FAULT] = frame_r[IDX_W'(sfpcd_pkg::B_FAULT)];
  end

  // priority compare: main fields and fault code, then time, then temperature
  always_comb begin
    chg_main = 1'b0;
    for (int i = 0; i < sfpcd_pkg::NUM_CMP; i++) begin
      if (stored_r[i] != new_f[i]) begin
        chg_main = 1'b1;
      end
    end
    if (stored_r[sfpcd_pkg::SLOT_FAULT] != new_f[sfpcd_pkg::SLOT_FAULT]) begin
      chg_main = 1'b1;
    end
  end

  assign chg_time = !chg_main &&
                    ((hour_r != frame_r[IDX_W'(sfpcd_pkg::B_HOUR)]) ||
                     (minute_r != frame_r[IDX_W'(sfpcd_pkg::B_MIN)]));
  assign temp_reached = !chg_main && !chg_time &&
                        (stored_r[sfpcd_pkg::SLOT_TEMP] != new_f[sfpcd_pkg::SLOT_TEMP]);
  assign elapsed   = s1_now_r - last_ms_r;
  assign temp_fast = (elapsed < {16'd0, temp_window_r});

  // temperature burst filter
  always_comb begin
    tcount_nxt  = tcount_r;
    temp_report = 1'b0;
    if (temp_reached) begin
      if (temp_fast) begin
        if (tcount_r >= burst_limit_r) begin
          temp_report = 1'b1;
          tcount_nxt  = 4'd0;
        end else begin
          tcount_nxt = tcount_r + 4'd1;
        end
      end else begin
        temp_report = 1'b1;
        tcount_nxt  = 4'd0;
      end
    end
  end

  assign changed = is_data && (chg_main || chg_time || temp_report);

  // stored state update on a good data frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sfpcd_pkg::NUM_FIELDS; i++) begin
        stored_r[i] <= 8'd0;
      end
      hour_r    <= 8'd0;
      minute_r  <= 8'd0;
      last_ms_r <= 32'd0;
      tcount_r  <= 4'd0;
    end else if (s1_go && s1_end_r && is_data) begin
      for (int i = 0; i < sfpcd_pkg::NUM_FIELDS; i++) begin
        stored_r[i] <= new_f[i];
      end
      if (chg_time) begin
        hour_r   <= frame_r[IDX_W'(sfpcd_pkg::B_HOUR)];
        minute_r <= frame_r[IDX_W'(sfpcd_pkg::B_MIN)];
      end
      if (temp_reached) begin
        last_ms_r <= s1_now_r;
      end
      tcount_r <= tcount_nxt;
    end
  end

  // result payload
  always_comb begin
    for (int i = 0; i < sfpcd_pkg::NUM_FIELDS; i++) begin
      rep_f[i] = is_data ? new_f[i] : stored_r[i];
    end
    atime = is_data ? {frame_r[IDX_W'(sfpcd_pkg::B_HOUR)],
                       frame_r[IDX_W'(sfpcd_pkg::B_MIN)]} : 16'd0;
    out_data_nxt = {7'd0, rep_f[7], atime, rep_f[6], rep_f[5], rep_f[4], rep_f[3],
                    rep_f[2], rep_f[1], rep_f[0], changed, cmd_code};
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  // byte count never runs past its saturation point
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_SAT)
    else $error("byte count past saturation");

  // a frame end always loads a result
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_end_r) |=> out_vld_r)
    else $error("frame end without result");

  // frame state restarts after every frame end
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_end_r) |=> (cnt_r == '0) && (sum_r == '0))
    else $error("frame state not cleared at frame end");

  // a non-data frame leaves the stored fields alone
  a_keep_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_end_r && !is_data) |=>
      $stable(stored_r[0]) && $stable(stored_r[sfpcd_pkg::SLOT_TEMP]) &&
      $stable(stored_r[sfpcd_pkg::SLOT_FAULT]) && $stable(tcount_r))
    else $error("stored fields changed by non-data frame");

  // a pending result is never overwritten before it is taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !(s1_go && s1_end_r))
    else $error("result overwritten while pending");
`endif

endmodule

`default_nettype wire
